// ===== hw/rtl/deque_with_linear_search_assert.svh =====
// Assertion macros shared by the deque modules.
`ifndef DEQUE_WITH_LINEAR_SEARCH_ASSERT_SVH
`define DEQUE_WITH_LINEAR_SEARCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DQLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DQLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dqls_pkg.sv =====
// Shared types and constants for the deque with linear search.
`timescale 1ns / 1ps

package dqls_pkg;

  // Storage size and derived widths.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int VAL_W    = 32;

  // Action codes carried on the input tuser.
  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_REM_FRONT = 3'd2,
    ACT_REM_BACK  = 3'd3,
    ACT_SEARCH    = 3'd4
  } action_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    ins_front;
    logic    ins_back;
    logic    rem_front;
    logic    rem_back;
    logic    scan_start;
    logic    scan_step;
    logic    set_res;
    status_t res_status;
    logic    load_out;
  } dqls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
    logic out_free;
  } dqls_sts_t;

endpackage

// ===== hw/rtl/deque_with_linear_search.sv =====
// Top level of the bounded deque with linear key search.
//
// Input channel (in_*): one word per action. in_tuser carries the action
// code (insert front, insert back, remove front, remove back, search) and
// in_tdata the signed 32-bit value or search key.
// Output channel (out_*): exactly one result word per input word, in order,
// with the status (ok, empty, full) and the found flag.
// Inserts, removals and unused codes load the result register from the done
// state once it is free; the store and pointers update at acceptance.
// A search scans the stored entries from the front: the scan reads one
// entry per cycle from the single read port of the entry memory and
// compares it in the next cycle; a hit ends it early. The next word is
// accepted in the cycle after a result is loaded.
// One word is in work at a time; in_tready is high whenever no word is in
// work, also while a finished result still waits in the output register.
// If the receiver stalls, one result is held and one more finishes behind
// it, after which the input side stops.
// Reset empties the list at once; no clearing pass is needed.
`timescale 1ns / 1ps

module deque_with_linear_search
  import dqls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] status, [2] found, [7:3] zero
);

  dqls_cmd_t               cmd;
  dqls_sts_t               sts;
  logic signed [VAL_W-1:0] value;

  assign value = in_tdata;

  dqls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  dqls_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .value      (value),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hw/rtl/dqls_datapath.sv =====
// Datapath: entry memory, ring pointers, search scan and output register.
`timescale 1ns / 1ps

module dqls_datapath
  import dqls_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dqls_cmd_t               cmd,
  output dqls_sts_t               sts,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    out_tready,
  output logic                    out_tvalid,
  output logic [7:0]              out_tdata
);

`include "deque_with_linear_search_assert.svh"

  logic [VAL_W-1:0]        mem [CAPACITY];
  logic [VAL_W-1:0]        rdata_r;
  logic [IDX_W-1:0]        front_r, front_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [VAL_W-1:0] key_r;
  logic [IDX_W-1:0]        scan_addr_r;
  logic [CNT_W-1:0]        scan_left_r;
  logic                    cmp_vld_r;
  logic                    found_r;
  status_t                 status_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic                    out_found_r;

  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [SUM_W-1:0] back_sum;
  logic [IDX_W-1:0] back_slot;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  logic             rd_issue;
  logic             hit;

  // Neighbor slots of the front, wrapping around the ring.
  assign front_dec = (front_r == '0) ? IDX_W'(CAPACITY - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IDX_W'(CAPACITY - 1)) ? '0 : front_r + 1'b1;

  // Slot just past the back entry; the sum stays below twice the capacity.
  assign back_sum  = SUM_W'(front_r) + SUM_W'(count_r);
  assign back_slot = (back_sum >= SUM_W'(CAPACITY)) ? IDX_W'(back_sum - SUM_W'(CAPACITY))
                                                    : IDX_W'(back_sum);

  assign wr_en   = cmd.ins_front | cmd.ins_back;
  assign wr_addr = cmd.ins_front ? front_dec : back_slot;

  // Pointer and count updates.
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    if (cmd.ins_front) begin
      front_nxt = front_dec;
      count_nxt = count_r + 1'b1;
    end else if (cmd.ins_back) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.rem_front) begin
      front_nxt = front_inc;
      count_nxt = count_r - 1'b1;
    end else if (cmd.rem_back) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry memory: one write port, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rdata_r <= mem[scan_addr_r];
    end
  end

  // Scan issues one read a cycle and compares it in the next cycle.
  assign rd_issue = cmd.scan_step && (scan_left_r != '0) && !found_r;
  assign hit      = cmp_vld_r && (rdata_r == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else if (cmd.scan_start) begin
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      cmp_vld_r <= rd_issue;
      if (cmd.set_res) begin
        found_r <= 1'b0;
      end else if (hit) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      key_r       <= value;
      scan_addr_r <= front_r;
      scan_left_r <= count_r;
    end else if (rd_issue) begin
      scan_addr_r <= (scan_addr_r == IDX_W'(CAPACITY - 1)) ? '0 : scan_addr_r + 1'b1;
      scan_left_r <= scan_left_r - 1'b1;
    end
  end

  // Pending result status, latched when the word is accepted.
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      status_r <= cmd.res_status;
    end
  end

  // Output register frees the input side while a result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_found_r, out_status_r};

  assign sts.full      = (count_r == CNT_W'(CAPACITY));
  assign sts.empty     = (count_r == '0);
  assign sts.scan_done = ((scan_left_r == '0) || found_r) && !cmp_vld_r;
  assign sts.out_free  = !out_valid_r || out_tready;

  `DQLS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY),
    "entry count exceeds capacity")
  `DQLS_ASSERT_NOW(a_found_from_scan, $rose(found_r), $past(cmd.scan_step),
    "found flag set outside a scan")
  `DQLS_ASSERT_NOW(a_load_when_free, cmd.load_out, !out_valid_r || out_tready,
    "result loaded over a word not yet taken")

endmodule

// ===== hw/rtl/dqls_ctrl.sv =====
// Controller: decodes actions and sequences the search scan.
`timescale 1ns / 1ps

module dqls_ctrl
  import dqls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [2:0] in_tuser,
  input  dqls_sts_t  sts,
  output dqls_cmd_t  cmd
);

`include "deque_with_linear_search_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t  state_r, state_nxt;
  logic    accept;
  action_t action;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign action    = action_t'(in_tuser);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.set_res = 1'b1;
          state_nxt   = S_DONE;
          case (action)
            ACT_INS_FRONT: begin
              if (sts.full) cmd.res_status = ST_FULL;
              else          cmd.ins_front  = 1'b1;
            end
            ACT_INS_BACK: begin
              if (sts.full) cmd.res_status = ST_FULL;
              else          cmd.ins_back   = 1'b1;
            end
            ACT_REM_FRONT: begin
              if (sts.empty) cmd.res_status = ST_EMPTY;
              else           cmd.rem_front  = 1'b1;
            end
            ACT_REM_BACK: begin
              if (sts.empty) cmd.res_status = ST_EMPTY;
              else           cmd.rem_back   = 1'b1;
            end
            ACT_SEARCH: begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
            default: begin
              cmd.res_status = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `DQLS_ASSERT_NEXT(a_search_scans, accept && (action == ACT_SEARCH), state_r == S_SCAN,
    "search word did not start a scan")
  `DQLS_ASSERT_NOW(a_no_remove_empty, cmd.rem_front || cmd.rem_back, !sts.empty,
    "removal issued on an empty list")
  `DQLS_ASSERT_NEXT(a_load_to_idle, cmd.load_out, state_r == S_IDLE,
    "controller not idle after result load")

endmodule
